// ===== design/mean_variance_stddev_macros.svh =====
// Assertion macros shared by the mean/variance/std-dev block.
`ifndef MEAN_VARIANCE_STDDEV_MACROS_SVH
`define MEAN_VARIANCE_STDDEV_MACROS_SVH

// Same-cycle implication, disabled while reset is low.
`define MVS_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is low.
`define MVS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/mvs_pkg.sv =====
// Shared constants, state type and command/status structs for the statistics block.
package mvs_pkg;

    localparam int MAX_SAMPLES = 65536;
    localparam int SAMPLE_W    = 16;
    localparam int CNT_W       = $clog2(MAX_SAMPLES + 1);
    localparam int SUM_W       = SAMPLE_W + CNT_W;
    localparam int SQ_W        = 2 * SAMPLE_W - 2 + CNT_W;
    localparam int Q_W         = SAMPLE_W + 1;
    localparam int S1R_W       = SUM_W + 1;
    localparam int PROD_W      = S1R_W + Q_W;
    localparam int DIV_W       = SQ_W + 1;
    localparam int DIV_CNT_W   = $clog2(DIV_W);
    localparam int MEAN_W      = 16;
    localparam int VAR_W       = 31;
    localparam int ROOT_W      = 16;
    localparam int RAD_W       = 2 * ROOT_W;
    localparam int SQRT_CNT_W  = $clog2(ROOT_W);
    localparam int TDATA_W     = MEAN_W + VAR_W + ROOT_W + CNT_W;

    localparam logic DIV_SEL_SUM = 1'b0;
    localparam logic DIV_SEL_T   = 1'b1;

    typedef enum logic [3:0] {
        ST_ACC,
        ST_QSTART,
        ST_QWAIT,
        ST_QFIX,
        ST_TMUL,
        ST_TSTART,
        ST_TWAIT,
        ST_VMUL,
        ST_VSEL,
        ST_SSTART,
        ST_SWAIT,
        ST_OUT
    } t_state;

    typedef struct packed {
        logic acc;
        logic div_start;
        logic div_sel;
        logic fix_q;
        logic t_calc;
        logic v_mul;
        logic v_sel;
        logic sqrt_start;
        logic load_out;
    } t_cmd;

    typedef struct packed {
        logic div_done;
        logic sqrt_done;
    } t_status;

endpackage

// ===== design/mean_variance_stddev.sv =====
// Top level: population mean, variance and standard deviation of sample blocks.
//
//  channel   dir  payload                                  end marker
//  s_axis    in   tdata[15:0] sample (signed Q1.15)        tlast = last sample of block
//  m_axis    out  tdata: mean, variance, std dev, count    tuser = samples dropped
//
// One sample is taken per cycle while a block accumulates (one square and add per cycle).
// After the last sample, s_axis is held off through two 48-step serial divisions,
// a 16-step serial root and the fixup states between them; longer if the previous result is still held.
// The result sits in an output register, so a new block accumulates while it waits.
// Reset (synchronous, active low) clears the accumulators and drops any pending result.
`include "mean_variance_stddev_macros.svh"

module mean_variance_stddev (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_s_axis_tvalid,
    output logic                            o_s_axis_tready,
    input  logic [15:0]                     i_s_axis_tdata,  // [15:0] sample
    input  logic                            i_s_axis_tlast,
    output logic                            o_m_axis_tvalid,
    input  logic                            i_m_axis_tready,
    // [15:0] mean_value, [46:16] variance_value, [62:47] std_dev, [79:63] sample_count
    output logic [mvs_pkg::TDATA_W-1:0]     o_m_axis_tdata,
    output logic                            o_m_axis_tuser   // [0] overflow
);

    mvs_pkg::t_cmd                  w_cmd;
    mvs_pkg::t_status               w_status;
    logic [mvs_pkg::MEAN_W-1:0]     w_mean;
    logic [mvs_pkg::VAR_W-1:0]      w_var;
    logic [mvs_pkg::ROOT_W-1:0]     w_std;
    logic [mvs_pkg::CNT_W-1:0]      w_count;
    logic                           w_ovf;

    mvs_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_s_axis_tvalid),
        .i_in_last   (i_s_axis_tlast),
        .i_out_ready (i_m_axis_tready),
        .i_status    (w_status),
        .o_in_ready  (o_s_axis_tready),
        .o_out_valid (o_m_axis_tvalid),
        .o_cmd       (w_cmd)
    );

    mvs_dpath u_dpath (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (w_cmd),
        .i_sample (signed'(i_s_axis_tdata)),
        .o_status (w_status),
        .o_mean   (w_mean),
        .o_var    (w_var),
        .o_std    (w_std),
        .o_count  (w_count),
        .o_ovf    (w_ovf)
    );

    assign o_m_axis_tdata = {w_count, w_std, w_var, w_mean};
    assign o_m_axis_tuser = w_ovf;

    `MVS_ASSERT_NEXT(a_last_holds_off, i_clk, i_rst_n, i_s_axis_tvalid && o_s_axis_tready && i_s_axis_tlast, !o_s_axis_tready, "input still ready after last sample")
    `MVS_ASSERT_IMPLY(a_count_nonzero, i_clk, i_rst_n, o_m_axis_tvalid, w_count != '0, "result with zero count")
    `MVS_ASSERT_IMPLY(a_root_floor, i_clk, i_rst_n, o_m_axis_tvalid, (33'(w_std) * 33'(w_std) <= 33'(w_var)) && ((33'(w_std) + 33'd1) * (33'(w_std) + 33'd1) > 33'(w_var)), "std dev is not the floored root of variance")
    `MVS_ASSERT_IMPLY(a_ovf_full, i_clk, i_rst_n, o_m_axis_tvalid && o_m_axis_tuser, w_count == mvs_pkg::CNT_W'(mvs_pkg::MAX_SAMPLES), "overflow flagged on a block that is not full")

endmodule

// ===== design/mvs_div.sv =====
// Restoring unsigned divider, one quotient bit per cycle.
module mvs_div (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [mvs_pkg::DIV_W-1:0]     i_dividend,
    input  logic [mvs_pkg::CNT_W-1:0]     i_divisor,
    output logic                          o_done,
    output logic [mvs_pkg::DIV_W-1:0]     o_quot,
    output logic [mvs_pkg::CNT_W-1:0]     o_rem
);

    logic                            r_busy, n_busy;
    logic [mvs_pkg::DIV_CNT_W-1:0]   r_cnt, n_cnt;
    logic [mvs_pkg::DIV_W-1:0]       r_quot, n_quot;
    logic [mvs_pkg::CNT_W-1:0]       r_rem, n_rem;
    logic [mvs_pkg::CNT_W-1:0]       r_div, n_div;
    logic [mvs_pkg::CNT_W:0]         w_trial;
    logic [mvs_pkg::CNT_W:0]         w_diff;
    logic                            w_ge;

    assign w_trial = {r_rem, r_quot[mvs_pkg::DIV_W-1]};
    assign w_ge    = w_trial >= {1'b0, r_div};
    assign w_diff  = w_trial - {1'b0, r_div};

    always_comb begin
        n_busy = r_busy;
        n_cnt  = r_cnt;
        n_quot = r_quot;
        n_rem  = r_rem;
        n_div  = r_div;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = mvs_pkg::DIV_CNT_W'(mvs_pkg::DIV_W - 1);
            n_quot = i_dividend;
            n_rem  = '0;
            n_div  = i_divisor;
        end else if (r_busy) begin
            n_quot = {r_quot[mvs_pkg::DIV_W-2:0], w_ge};
            n_rem  = w_ge ? w_diff[mvs_pkg::CNT_W-1:0] : w_trial[mvs_pkg::CNT_W-1:0];
            if (r_cnt == '0) begin
                n_busy = 1'b0;
            end else begin
                n_cnt = r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_cnt  <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_quot <= n_quot;
        r_rem  <= n_rem;
        r_div  <= n_div;
    end

    // results are final at the edge that ends the last step
    assign o_done = r_busy && (r_cnt == '0);
    assign o_quot = r_quot;
    assign o_rem  = r_rem;

endmodule

// ===== design/mvs_isqrt.sv =====
// Digit-by-digit integer square root, one root bit per cycle.
module mvs_isqrt (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [mvs_pkg::VAR_W-1:0]     i_radicand,
    output logic                          o_done,
    output logic [mvs_pkg::ROOT_W-1:0]    o_root
);

    logic                             r_busy, n_busy;
    logic [mvs_pkg::SQRT_CNT_W-1:0]   r_cnt, n_cnt;
    logic [mvs_pkg::RAD_W-1:0]        r_rad, n_rad;
    logic [mvs_pkg::ROOT_W+1:0]       r_rem, n_rem;
    logic [mvs_pkg::ROOT_W-1:0]       r_root, n_root;
    logic [mvs_pkg::ROOT_W+3:0]       w_acc;
    logic [mvs_pkg::ROOT_W+3:0]       w_trial;
    logic [mvs_pkg::ROOT_W+3:0]       w_diff;
    logic                             w_ge;

    assign w_acc   = {r_rem, r_rad[mvs_pkg::RAD_W-1 -: 2]};
    assign w_trial = {2'b00, r_root, 2'b01};
    assign w_ge    = w_acc >= w_trial;
    assign w_diff  = w_acc - w_trial;

    always_comb begin
        n_busy = r_busy;
        n_cnt  = r_cnt;
        n_rad  = r_rad;
        n_rem  = r_rem;
        n_root = r_root;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = mvs_pkg::SQRT_CNT_W'(mvs_pkg::ROOT_W - 1);
            n_rad  = mvs_pkg::RAD_W'(i_radicand);
            n_rem  = '0;
            n_root = '0;
        end else if (r_busy) begin
            n_rad  = {r_rad[mvs_pkg::RAD_W-3:0], 2'b00};
            n_rem  = w_ge ? w_diff[mvs_pkg::ROOT_W+1:0] : w_acc[mvs_pkg::ROOT_W+1:0];
            n_root = {r_root[mvs_pkg::ROOT_W-2:0], w_ge};
            if (r_cnt == '0) begin
                n_busy = 1'b0;
            end else begin
                n_cnt = r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_cnt  <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rad  <= n_rad;
        r_rem  <= n_rem;
        r_root <= n_root;
    end

    assign o_done = r_busy && (r_cnt == '0);
    assign o_root = r_root;

endmodule

// ===== design/mvs_dpath.sv =====
// Datapath: accumulators, floor mean, exact variance, root and result registers.
module mvs_dpath (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  mvs_pkg::t_cmd                        i_cmd,
    input  logic signed [mvs_pkg::SAMPLE_W-1:0]  i_sample,
    output mvs_pkg::t_status                     o_status,
    output logic [mvs_pkg::MEAN_W-1:0]           o_mean,
    output logic [mvs_pkg::VAR_W-1:0]            o_var,
    output logic [mvs_pkg::ROOT_W-1:0]           o_std,
    output logic [mvs_pkg::CNT_W-1:0]            o_count,
    output logic                                 o_ovf
);

    // accumulators
    logic [mvs_pkg::CNT_W-1:0]          r_count, n_count;
    logic signed [mvs_pkg::SUM_W-1:0]   r_sum, n_sum;
    logic [mvs_pkg::SQ_W-1:0]           r_sq, n_sq;
    logic                               r_drop, n_drop;

    // working registers
    logic signed [mvs_pkg::Q_W-1:0]     r_q, n_q;
    logic [mvs_pkg::CNT_W-1:0]          r_r, n_r;
    logic [mvs_pkg::DIV_W-1:0]          r_t;
    logic [2*mvs_pkg::CNT_W-1:0]        r_nb, r_rr;
    logic [mvs_pkg::VAR_W-1:0]          r_var;

    // result registers
    logic [mvs_pkg::MEAN_W-1:0]         r_o_mean;
    logic [mvs_pkg::VAR_W-1:0]          r_o_var;
    logic [mvs_pkg::ROOT_W-1:0]         r_o_std;
    logic [mvs_pkg::CNT_W-1:0]          r_o_count;
    logic                               r_o_ovf;

    logic signed [2*mvs_pkg::SAMPLE_W-1:0] w_sq;
    logic [mvs_pkg::SUM_W-1:0]          w_abs_sum;
    logic [mvs_pkg::DIV_W-1:0]          w_dividend;
    logic                               w_div_done;
    logic [mvs_pkg::DIV_W-1:0]          w_quot;
    logic [mvs_pkg::CNT_W-1:0]          w_rem;
    logic [mvs_pkg::Q_W-1:0]            w_q0;
    logic signed [mvs_pkg::S1R_W-1:0]   w_s1r;
    logic signed [mvs_pkg::PROD_W-1:0]  w_prod;
    logic [mvs_pkg::PROD_W-1:0]         w_t;
    logic                               w_sqrt_done;
    logic [mvs_pkg::ROOT_W-1:0]         w_root;

    assign w_sq      = (2*mvs_pkg::SAMPLE_W)'(i_sample) * (2*mvs_pkg::SAMPLE_W)'(i_sample);
    assign w_abs_sum = r_sum[mvs_pkg::SUM_W-1] ? unsigned'(-r_sum) : unsigned'(r_sum);
    assign w_dividend = (i_cmd.div_sel == mvs_pkg::DIV_SEL_T) ? r_t
                                                              : mvs_pkg::DIV_W'(w_abs_sum);
    assign w_q0 = w_quot[mvs_pkg::Q_W-1:0];

    // t = S2 - q*(S1 + r), the sum of squared deviations from the floored mean
    assign w_s1r  = mvs_pkg::S1R_W'(r_sum) + mvs_pkg::S1R_W'(signed'({1'b0, r_r}));
    assign w_prod = mvs_pkg::PROD_W'(r_q) * mvs_pkg::PROD_W'(w_s1r);
    assign w_t    = mvs_pkg::PROD_W'(r_sq) - w_prod;

    mvs_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (w_dividend),
        .i_divisor  (r_count),
        .o_done     (w_div_done),
        .o_quot     (w_quot),
        .o_rem      (w_rem)
    );

    mvs_isqrt u_isqrt (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.sqrt_start),
        .i_radicand (r_var),
        .o_done     (w_sqrt_done),
        .o_root     (w_root)
    );

    always_comb begin
        n_count = r_count;
        n_sum   = r_sum;
        n_sq    = r_sq;
        n_drop  = r_drop;
        if (i_cmd.acc) begin
            if (r_count < mvs_pkg::CNT_W'(mvs_pkg::MAX_SAMPLES)) begin
                n_count = r_count + 1'b1;
                n_sum   = r_sum + mvs_pkg::SUM_W'(i_sample);
                n_sq    = r_sq + mvs_pkg::SQ_W'(unsigned'(w_sq));
            end else begin
                n_drop = 1'b1;
            end
        end else if (i_cmd.load_out) begin
            n_count = '0;
            n_sum   = '0;
            n_sq    = '0;
            n_drop  = 1'b0;
        end
    end

    // floor division fixup for a negative sum
    always_comb begin
        n_q = signed'(w_q0);
        n_r = w_rem;
        if (r_sum[mvs_pkg::SUM_W-1]) begin
            if (w_rem == '0) begin
                n_q = signed'(mvs_pkg::Q_W'(0) - w_q0);
                n_r = '0;
            end else begin
                n_q = signed'(~w_q0);
                n_r = r_count - w_rem;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_sum   <= '0;
            r_sq    <= '0;
            r_drop  <= 1'b0;
        end else begin
            r_count <= n_count;
            r_sum   <= n_sum;
            r_sq    <= n_sq;
            r_drop  <= n_drop;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.fix_q) begin
            r_q <= n_q;
            r_r <= n_r;
        end
        if (i_cmd.t_calc) begin
            r_t <= w_t[mvs_pkg::DIV_W-1:0];
        end
        if (i_cmd.v_mul) begin
            r_nb <= (2*mvs_pkg::CNT_W)'(r_count) * (2*mvs_pkg::CNT_W)'(w_rem);
            r_rr <= (2*mvs_pkg::CNT_W)'(r_r) * (2*mvs_pkg::CNT_W)'(r_r);
        end
        // a*n + b = t; subtract one when n*b falls short of r^2
        if (i_cmd.v_sel) begin
            r_var <= (r_nb >= r_rr) ? w_quot[mvs_pkg::VAR_W-1:0]
                                    : w_quot[mvs_pkg::VAR_W-1:0] - 1'b1;
        end
        if (i_cmd.load_out) begin
            r_o_mean  <= r_q[mvs_pkg::MEAN_W-1:0];
            r_o_var   <= r_var;
            r_o_std   <= w_root;
            r_o_count <= r_count;
            r_o_ovf   <= r_drop;
        end
    end

    assign o_status.div_done  = w_div_done;
    assign o_status.sqrt_done = w_sqrt_done;
    assign o_mean  = r_o_mean;
    assign o_var   = r_o_var;
    assign o_std   = r_o_std;
    assign o_count = r_o_count;
    assign o_ovf   = r_o_ovf;

endmodule

// ===== design/mvs_ctrl.sv =====
// Controller: sequences accumulation, the two divisions, the root and the result request.
module mvs_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic              i_in_last,
    input  logic              i_out_ready,
    input  mvs_pkg::t_status  i_status,
    output logic              o_in_ready,
    output logic              o_out_valid,
    output mvs_pkg::t_cmd     o_cmd
);

    mvs_pkg::t_state r_state, n_state;
    logic            r_out_valid, n_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= mvs_pkg::ST_ACC;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state     = r_state;
        o_cmd       = '0;
        o_in_ready  = 1'b0;
        n_out_valid = r_out_valid && !i_out_ready;
        case (r_state)
            mvs_pkg::ST_ACC: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.acc = 1'b1;
                    if (i_in_last) begin
                        n_state = mvs_pkg::ST_QSTART;
                    end
                end
            end
            mvs_pkg::ST_QSTART: begin
                o_cmd.div_start = 1'b1;
                o_cmd.div_sel   = mvs_pkg::DIV_SEL_SUM;
                n_state         = mvs_pkg::ST_QWAIT;
            end
            mvs_pkg::ST_QWAIT: begin
                if (i_status.div_done) begin
                    n_state = mvs_pkg::ST_QFIX;
                end
            end
            mvs_pkg::ST_QFIX: begin
                o_cmd.fix_q = 1'b1;
                n_state     = mvs_pkg::ST_TMUL;
            end
            mvs_pkg::ST_TMUL: begin
                o_cmd.t_calc = 1'b1;
                n_state      = mvs_pkg::ST_TSTART;
            end
            mvs_pkg::ST_TSTART: begin
                o_cmd.div_start = 1'b1;
                o_cmd.div_sel   = mvs_pkg::DIV_SEL_T;
                n_state         = mvs_pkg::ST_TWAIT;
            end
            mvs_pkg::ST_TWAIT: begin
                if (i_status.div_done) begin
                    n_state = mvs_pkg::ST_VMUL;
                end
            end
            mvs_pkg::ST_VMUL: begin
                o_cmd.v_mul = 1'b1;
                n_state     = mvs_pkg::ST_VSEL;
            end
            mvs_pkg::ST_VSEL: begin
                o_cmd.v_sel = 1'b1;
                n_state     = mvs_pkg::ST_SSTART;
            end
            mvs_pkg::ST_SSTART: begin
                o_cmd.sqrt_start = 1'b1;
                n_state          = mvs_pkg::ST_SWAIT;
            end
            mvs_pkg::ST_SWAIT: begin
                if (i_status.sqrt_done) begin
                    n_state = mvs_pkg::ST_OUT;
                end
            end
            mvs_pkg::ST_OUT: begin
                // hand over only once the previous request has left
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.load_out = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = mvs_pkg::ST_ACC;
                end
            end
            default: begin
                n_state = mvs_pkg::ST_ACC;
            end
        endcase
    end

    assign o_out_valid = r_out_valid;

endmodule

// ===== verif/mean_variance_stddev_checker.sv =====
// Checker for the statistics block: predicts mean, variance, std dev and count per sample block.
module mean_variance_stddev_checker (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_s_tvalid,
    input  logic                        i_s_tready,
    input  logic [15:0]                 i_s_tdata,   // [15:0] sample
    input  logic                        i_s_tlast,
    input  logic                        i_m_tvalid,
    input  logic                        i_m_tready,
    // [15:0] mean_value, [46:16] variance_value, [62:47] std_dev, [79:63] sample_count
    input  logic [mvs_pkg::TDATA_W-1:0] i_m_tdata,
    input  logic                        i_m_tuser,   // [0] overflow
    output int                          o_fail_count,
    output int                          o_pending
);

    typedef struct packed {
        logic signed [mvs_pkg::MEAN_W-1:0] mean;
        logic [mvs_pkg::VAR_W-1:0]         variance;
        logic [mvs_pkg::ROOT_W-1:0]        std_dev;
        logic [mvs_pkg::CNT_W-1:0]         count;
        logic                              dropped;
    } t_block_stats;

    logic [mvs_pkg::CNT_W-1:0]        n_kept;
    logic signed [mvs_pkg::SUM_W-1:0] sum_kept;
    logic [mvs_pkg::SQ_W-1:0]         sq_kept;
    logic                             dropped;
    t_block_stats                     stats_due[$];
    int                               fails = 0;

    function automatic logic [mvs_pkg::ROOT_W-1:0] floor_root(input longint v);
        logic [mvs_pkg::ROOT_W-1:0] root;
        longint                     trial;
        root = '0;
        for (int b = mvs_pkg::ROOT_W - 1; b >= 0; b--) begin
            trial = longint'(root | (mvs_pkg::ROOT_W'(1) << b));
            if (trial * trial <= v)
                root = root | (mvs_pkg::ROOT_W'(1) << b);
        end
        return root;
    endfunction

    // Population stats of the samples kept so far; variance is floor((n*S2 - S1^2)/n^2).
    function automatic t_block_stats close_block();
        t_block_stats r;
        longint       n;
        longint       s1;
        longint       s2;
        longint       q;
        longint       spread;
        r  = '0;
        n  = longint'(n_kept);
        s1 = longint'(sum_kept);
        s2 = longint'(sq_kept);
        if (n != 0) begin
            q = s1 / n;
            if (s1 % n != 0 && s1 < 0)
                q = q - 1;
            spread     = (n * s2 - s1 * s1) / (n * n);
            r.mean     = q[mvs_pkg::MEAN_W-1:0];
            r.variance = spread[mvs_pkg::VAR_W-1:0];
            r.std_dev  = floor_root(spread);
        end
        r.count   = n_kept;
        r.dropped = dropped;
        return r;
    endfunction

    task automatic check_field(input string field, input longint want, input longint got);
        if (want != got) begin
            $display("%0t mismatch in %s: expected %0d, got %0d", $time, field, want, got);
            fails++;
        end
    endtask

    always @(posedge i_clk) begin : watch
        logic signed [mvs_pkg::SAMPLE_W-1:0] x;
        t_block_stats                        want;
        if (!i_rst_n) begin
            n_kept   = '0;
            sum_kept = '0;
            sq_kept  = '0;
            dropped  = 1'b0;
            stats_due.delete();
        end else begin
            if (i_s_tvalid && i_s_tready) begin
                x = i_s_tdata;
                if (n_kept < mvs_pkg::CNT_W'(mvs_pkg::MAX_SAMPLES)) begin
                    n_kept   = n_kept + 1'b1;
                    sum_kept = sum_kept + x;
                    sq_kept  = sq_kept + mvs_pkg::SQ_W'(longint'(x) * longint'(x));
                end else begin
                    dropped = 1'b1;
                end
                if (i_s_tlast) begin
                    stats_due = {stats_due, close_block()};
                    n_kept   = '0;
                    sum_kept = '0;
                    sq_kept  = '0;
                    dropped  = 1'b0;
                end
            end
            if (i_m_tvalid && i_m_tready) begin
                if (stats_due.size() == 0) begin
                    $display("%0t unexpected result: expected none, got tdata %h tuser %b",
                             $time, i_m_tdata, i_m_tuser);
                    fails++;
                end else begin
                    want = stats_due.pop_front();
                    check_field("mean_value", longint'(want.mean),
                                longint'($signed(i_m_tdata[mvs_pkg::MEAN_W-1:0])));
                    check_field("variance_value", longint'(want.variance),
                                longint'(i_m_tdata[mvs_pkg::MEAN_W +: mvs_pkg::VAR_W]));
                    check_field("std_dev", longint'(want.std_dev),
                                longint'(i_m_tdata[mvs_pkg::MEAN_W+mvs_pkg::VAR_W +:
                                                   mvs_pkg::ROOT_W]));
                    check_field("sample_count", longint'(want.count),
                                longint'(i_m_tdata[mvs_pkg::MEAN_W+mvs_pkg::VAR_W+
                                                   mvs_pkg::ROOT_W +: mvs_pkg::CNT_W]));
                    check_field("overflow", longint'(want.dropped), longint'(i_m_tuser));
                end
            end
        end
        o_pending    <= stats_due.size();
        o_fail_count <= fails;
    end

endmodule

// ===== verif/mean_variance_stddev_tb.sv =====
// Testbench top: drives sample blocks into the statistics block and gives the verdict.
module mean_variance_stddev_tb;

    localparam int LONG_HOLD      = 400;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int DRAIN_CYCLES   = 300;

    typedef enum int {SPREAD_FULL, SPREAD_EXTREME, SPREAD_CLUSTER, SPREAD_CONSTANT} t_spread;

    // {last, sample}
    localparam logic [16:0] OPENING [20] = '{
        {1'b1, 16'h8000},
        {1'b1, 16'h7FFF},
        {1'b1, 16'h0000},
        {1'b1, 16'hFFFF},
        {1'b0, 16'h8000}, {1'b1, 16'h7FFF},
        {1'b0, 16'h7FFF}, {1'b1, 16'h7FFF},
        {1'b0, 16'hFFFF}, {1'b0, 16'h0000}, {1'b1, 16'h0000},
        {1'b0, 16'h0001}, {1'b0, 16'h0000}, {1'b1, 16'h0000},
        {1'b0, 16'h8000}, {1'b1, 16'h8000},
        {1'b0, 16'h0005}, {1'b0, 16'hFFF9}, {1'b0, 16'h0003}, {1'b1, 16'h000C}
    };

    logic                          i_clk           = 1'b0;
    logic                          i_rst_n         = 1'b0;
    logic                          i_s_axis_tvalid = 1'b0;
    logic                          o_s_axis_tready;
    logic [15:0]                   i_s_axis_tdata  = '0;   // [15:0] sample
    logic                          i_s_axis_tlast  = 1'b0;
    logic                          o_m_axis_tvalid;
    logic                          i_m_axis_tready = 1'b0;
    // [15:0] mean_value, [46:16] variance_value, [62:47] std_dev, [79:63] sample_count
    logic [mvs_pkg::TDATA_W-1:0]   o_m_axis_tdata;
    logic                          o_m_axis_tuser;         // [0] overflow

    int   send_idle_pct = 36;
    int   recv_idle_pct = 54;
    logic hold_req      = 1'b0;
    int   samples_sent  = 0;
    int   blocks_sent   = 0;
    int   quiet_cycles  = 0;
    int   fail_count;
    int   pending;

    mean_variance_stddev u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tlast  (i_s_axis_tlast),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser)
    );

    mean_variance_stddev_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_s_tvalid   (i_s_axis_tvalid),
        .i_s_tready   (o_s_axis_tready),
        .i_s_tdata    (i_s_axis_tdata),
        .i_s_tlast    (i_s_axis_tlast),
        .i_m_tvalid   (o_m_axis_tvalid),
        .i_m_tready   (i_m_axis_tready),
        .i_m_tdata    (o_m_axis_tdata),
        .i_m_tuser    (o_m_axis_tuser),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Result side: random stalls, plus one long hold-off when requested.
    initial begin : result_side
        logic armed;
        armed = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_req && !armed) begin
                armed = 1'b1;
                for (int k = 0; k < LONG_HOLD; k++) begin
                    i_m_axis_tready <= 1'b0;
                    @(posedge i_clk);
                end
            end
            if (!hold_req)
                armed = 1'b0;
            i_m_axis_tready <= (recv_idle_pct == 0) || ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        if ((i_s_axis_tvalid && o_s_axis_tready) || (o_m_axis_tvalid && i_m_axis_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles == WATCHDOG_LIMIT) begin
            $display("%0t no request accepted for %0d cycles", $time, WATCHDOG_LIMIT);
            $display("mean_variance_stddev_tb failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic send_sample(input logic [15:0] value, input logic is_last);
        while (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct) begin
            i_s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= value;
        i_s_axis_tlast  <= is_last;
        @(posedge i_clk);
        while (!o_s_axis_tready)
            @(posedge i_clk);
        samples_sent++;
        if (is_last)
            blocks_sent++;
    endtask

    function automatic logic [15:0] pick_sample(input t_spread spread, input logic [15:0] center);
        case (spread)
            SPREAD_EXTREME:  return $urandom_range(0, 1) ? 16'h8000 : 16'h7FFF;
            SPREAD_CLUSTER:  return center + 16'($urandom_range(0, 64)) - 16'd32;
            SPREAD_CONSTANT: return center;
            default:         return 16'($urandom);
        endcase
    endfunction

    task automatic send_block(input int len, input t_spread spread);
        logic [15:0] center;
        center = 16'($urandom);
        for (int k = 0; k < len; k++)
            send_sample(pick_sample(spread, center), k == len - 1);
    endtask

    task automatic random_blocks(input int target);
        int first;
        int len;
        first = samples_sent;
        while (samples_sent - first < target) begin
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(25, 200) : $urandom_range(1, 24);
            send_block(len, t_spread'($urandom_range(0, 3)));
        end
    endtask

    // Pause the sender until every block result has come back.
    task automatic wait_drained();
        i_s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0)
            @(posedge i_clk);
    endtask

    initial begin : stimulus
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int k = 0; k < 20; k++)
            send_sample(OPENING[k][15:0], OPENING[k][16]);
        random_blocks(600);
        wait_drained();

        send_idle_pct <= 54;
        recv_idle_pct <= 36;
        random_blocks(600);
        wait_drained();

        send_idle_pct <= 0;
        recv_idle_pct <= 0;
        // long result stall: one result parked, next block done, input must back up
        hold_req <= 1'b1;
        for (int b = 0; b < 6; b++)
            send_block($urandom_range(3, 10), t_spread'($urandom_range(0, 3)));
        hold_req <= 1'b0;
        wait_drained();
        random_blocks(600);
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Covered %0d samples in %0d blocks: field extremes, negative mean rounding,",
                 samples_sent, blocks_sent);
        $display("both-side stalls, a long result hold-off and back-to-back blocks.");
        if (fail_count == 0 && pending == 0)
            $display("mean_variance_stddev_tb passed");
        else
            $display("mean_variance_stddev_tb failed");
        $finish;
    end

endmodule
